>>> design/multi_slot_interval_timer_bank_unit_macros.svh
// assertion macros for the timer bank checker
// no dependencies; included by the checker module
`ifndef MULTI_SLOT_INTERVAL_TIMER_BANK_UNIT_MACROS_SVH
`define MULTI_SLOT_INTERVAL_TIMER_BANK_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define MSITB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define MSITB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/msitb_pkg.sv
// shared types and constants for the interval timer bank
// no dependencies; used by the controller, datapath, top and checker
package msitb_pkg;

	localparam int NUM_SLOTS_DEF = 16;

	// beat widths on the stream ports
	localparam int IN_TDATA_W  = 72;
	localparam int IN_TUSER_W  = 3;
	localparam int OUT_TDATA_W = 8;
	localparam int OUT_TUSER_W = 2;
	localparam int SLOT_W      = 4;
	localparam int TIME_W      = 32;

	typedef enum logic [2:0] {
		K_TICK       = 3'd0,
		K_ALLOC      = 3'd1,
		K_RELEASE    = 3'd2,
		K_START      = 3'd3,
		K_STOP       = 3'd4,
		K_CLEAR      = 3'd5,
		K_SET_PERIOD = 3'd6,
		K_SET_REPEAT = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		EV_DONE    = 2'd0,
		EV_EXPIRED = 2'd1,
		EV_REFUSED = 2'd2
	} ev_t;

	// controller to datapath
	typedef struct packed {
		logic cap;          // take the input beat
		logic scan_start;   // tick: clear counter, read slot 0
		logic tick_step;    // tick: evaluate current slot, read next
		logic emit_close;   // closing result of a tick
		logic emit_refuse;  // allocate with the bank full
		logic alloc_start;  // allocate: clear counter
		logic alloc_skip;   // allocate: slot taken, move on
		logic alloc_claim;  // allocate: claim current slot
		logic op_apply;     // slot item: apply and answer
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		kind_t kind;
		logic  full;
		logic  cur_free;
		logic  fire;
		logic  scan_last;
		logic  out_free;
	} stat_t;

endpackage

>>> design/msitb_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module msitb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, holds its data while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> design/msitb_ctrl.sv
// sequencing state machine of the timer bank
// depends on msitb_pkg
module msitb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  msitb_pkg::stat_t    stat,
	output msitb_pkg::cmd_t     cmd
);
	import msitb_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_DECODE = 5'b00010,
		S_TICK   = 5'b00100,
		S_CLOSE  = 5'b01000,
		S_ALLOC  = 5'b10000
	} state_t;

	state_t state_q, state_nxt;

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.cap   = 1'b1;
					state_nxt = S_DECODE;
				end
			end
			S_DECODE: begin
				case (stat.kind)
					K_TICK: begin
						cmd.scan_start = 1'b1;
						state_nxt      = S_TICK;
					end
					K_ALLOC: begin
						if (!stat.full) begin
							cmd.alloc_start = 1'b1;
							state_nxt       = S_ALLOC;
						end else if (stat.out_free) begin
							cmd.emit_refuse = 1'b1;
							state_nxt       = S_IDLE;
						end
					end
					default: begin
						if (stat.out_free) begin
							cmd.op_apply = 1'b1;
							state_nxt    = S_IDLE;
						end
					end
				endcase
			end
			S_TICK: begin
				// a firing slot waits for room in the output register
				if (!stat.fire || stat.out_free) begin
					cmd.tick_step = 1'b1;
					if (stat.scan_last) begin
						state_nxt = S_CLOSE;
					end
				end
			end
			S_CLOSE: begin
				if (stat.out_free) begin
					cmd.emit_close = 1'b1;
					state_nxt      = S_IDLE;
				end
			end
			S_ALLOC: begin
				if (!stat.cur_free) begin
					cmd.alloc_skip = 1'b1;
				end else if (stat.out_free) begin
					cmd.alloc_claim = 1'b1;
					state_nxt       = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

>>> design/msitb_dp.sv
// datapath of the timer bank: slot flags, period and elapsed memories,
// slot counter and output register; depends on msitb_pkg and msitb_ram
module msitb_dp #(
	parameter int NUM_SLOTS = msitb_pkg::NUM_SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  msitb_pkg::cmd_t                  cmd,
	output msitb_pkg::stat_t                 stat,
	input  msitb_pkg::kind_t                 in_kind,
	input  logic [msitb_pkg::SLOT_W-1:0]     in_slot,
	input  logic [msitb_pkg::TIME_W-1:0]     in_interval_ms,
	input  logic                             in_repeat_flag,
	input  logic [msitb_pkg::TIME_W-1:0]     in_delta_ms,
	output logic                             out_valid,
	input  logic                             out_ready,
	output msitb_pkg::ev_t                   out_event_res,
	output logic [msitb_pkg::SLOT_W-1:0]     out_result_slot,
	output logic                             out_last
);
	import msitb_pkg::*;

	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW = $clog2(NUM_SLOTS + 1);
	localparam int XW = IW + SLOT_W;

	// captured item
	kind_t              kind_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [TIME_W-1:0]  ival_q;
	logic               rep_q;
	logic [TIME_W-1:0]  delta_q;

	logic [NUM_SLOTS-1:0] used_q, running_q, periodic_q;
	logic [CW-1:0]        used_count_q;
	logic [IW-1:0]        cnt_q;

	logic               out_valid_q;
	ev_t                out_ev_q;
	logic [SLOT_W-1:0]  out_slot_q;
	logic               out_last_q;

	logic [XW-1:0]      slot_wide, cnt_wide;
	logic [IW-1:0]      slot_idx;
	logic               slot_ok, out_free, act, fire;
	logic [TIME_W:0]    sum;
	logic [TIME_W-1:0]  sat;
	logic [TIME_W-1:0]  el_rdata, per_rdata, el_wdata, per_wdata;
	logic [IW-1:0]      el_waddr, per_waddr, rd_addr;
	logic               el_we, per_we, rd_en;

	// capture of the accepted beat
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			kind_q  <= in_kind;
			slot_q  <= in_slot;
			ival_q  <= in_interval_ms;
			rep_q   <= in_repeat_flag;
			delta_q <= in_delta_ms;
		end
	end

	// addressed slot check
	assign slot_wide = XW'(slot_q);
	assign slot_idx  = slot_wide[IW-1:0];
	assign slot_ok   = (slot_wide < XW'(NUM_SLOTS)) && used_q[slot_idx];
	assign cnt_wide  = XW'(cnt_q);

	// saturating add and compare for the slot under the counter
	assign act  = used_q[cnt_q] && running_q[cnt_q];
	assign sum  = {1'b0, el_rdata} + {1'b0, delta_q};
	assign sat  = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
	assign fire = act && (sat >= per_rdata);

	assign out_free = !out_valid_q || out_ready;

	// status to the controller
	always_comb begin
		stat.kind      = kind_q;
		stat.full      = used_count_q >= CW'(NUM_SLOTS);
		stat.cur_free  = !used_q[cnt_q];
		stat.fire      = fire;
		stat.scan_last = cnt_q == IW'(NUM_SLOTS - 1);
		stat.out_free  = out_free;
	end

	// slot counter shared by tick and allocate scans
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.scan_start || cmd.alloc_start) begin
			cnt_q <= '0;
		end else if (cmd.tick_step || cmd.alloc_skip) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// memory reads run one slot ahead of the evaluation
	assign rd_en   = cmd.scan_start || cmd.tick_step;
	assign rd_addr = cmd.scan_start ? '0 : cnt_q + 1'b1;

	// elapsed memory write
	always_comb begin
		el_we    = 1'b0;
		el_waddr = cnt_q;
		el_wdata = '0;
		if (cmd.tick_step && act) begin
			el_we    = 1'b1;
			el_wdata = (fire && periodic_q[cnt_q]) ? '0 : sat;
		end
		if (cmd.alloc_claim) begin
			el_we = 1'b1;
		end
		if (cmd.op_apply && slot_ok && (kind_q == K_START || kind_q == K_CLEAR)) begin
			el_we    = 1'b1;
			el_waddr = slot_idx;
		end
	end

	// period memory write
	always_comb begin
		per_we    = 1'b0;
		per_waddr = cnt_q;
		per_wdata = ival_q;
		if (cmd.alloc_claim) begin
			per_we = 1'b1;
		end
		if (cmd.op_apply && slot_ok && kind_q == K_SET_PERIOD) begin
			per_we    = 1'b1;
			per_waddr = slot_idx;
		end
	end

	msitb_ram #(.WIDTH(TIME_W), .DEPTH(NUM_SLOTS)) u_elapsed (
		.clk   (clk),
		.we    (el_we),
		.waddr (el_waddr),
		.wdata (el_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (el_rdata)
	);

	msitb_ram #(.WIDTH(TIME_W), .DEPTH(NUM_SLOTS)) u_period (
		.clk   (clk),
		.we    (per_we),
		.waddr (per_waddr),
		.wdata (per_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (per_rdata)
	);

	// slot flags and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q       <= '0;
			running_q    <= '0;
			periodic_q   <= '0;
			used_count_q <= '0;
		end else begin
			if (cmd.tick_step && fire && !periodic_q[cnt_q]) begin
				running_q[cnt_q] <= 1'b0;
			end
			if (cmd.alloc_claim) begin
				used_q[cnt_q]     <= 1'b1;
				running_q[cnt_q]  <= 1'b0;
				periodic_q[cnt_q] <= rep_q;
				used_count_q      <= used_count_q + 1'b1;
			end
			if (cmd.op_apply && slot_ok) begin
				case (kind_q)
					K_RELEASE: begin
						used_q[slot_idx]    <= 1'b0;
						running_q[slot_idx] <= 1'b0;
						used_count_q        <= used_count_q - 1'b1;
					end
					K_START: begin
						running_q[slot_idx] <= 1'b1;
					end
					K_STOP: begin
						running_q[slot_idx] <= 1'b0;
					end
					K_SET_REPEAT: begin
						periodic_q[slot_idx] <= rep_q;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.tick_step && fire) || cmd.emit_close || cmd.emit_refuse
				|| cmd.op_apply || cmd.alloc_claim) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.tick_step && fire) begin
			out_ev_q   <= EV_EXPIRED;
			out_slot_q <= cnt_wide[SLOT_W-1:0];
			out_last_q <= 1'b0;
		end else if (cmd.emit_close) begin
			out_ev_q   <= EV_DONE;
			out_slot_q <= '0;
			out_last_q <= 1'b1;
		end else if (cmd.emit_refuse) begin
			out_ev_q   <= EV_REFUSED;
			out_slot_q <= '0;
			out_last_q <= 1'b1;
		end else if (cmd.op_apply) begin
			out_ev_q   <= slot_ok ? EV_DONE : EV_REFUSED;
			out_slot_q <= slot_q;
			out_last_q <= 1'b1;
		end else if (cmd.alloc_claim) begin
			out_ev_q   <= EV_DONE;
			out_slot_q <= cnt_wide[SLOT_W-1:0];
			out_last_q <= 1'b1;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_event_res   = out_ev_q;
	assign out_result_slot = out_slot_q;
	assign out_last        = out_last_q;

endmodule

>>> design/multi_slot_interval_timer_bank_unit.sv
// Bank of NUM_SLOTS interval timer slots driven by command beats on a stream
// input. A tick beat walks every slot once, one slot per clock unless a
// firing slot waits for room in the output register, adding delta_ms with
// saturation to each running slot in use and sending one expiry beat per
// slot that reaches its interval, then a closing beat with tlast set.
// Allocate claims the lowest free slot; the other commands act on one slot
// and answer with a single beat. The tick walk reads the period and elapsed
// memories; an allocate finds its slot by a free-slot scan. A result
// waiting in the output register does not stop the next beat being taken.
// No clearing pass after reset: slot memory contents are only used for
// slots in use, which an allocate writes first.
// Depends on msitb_pkg, msitb_ctrl, msitb_dp and msitb_ram.
module multi_slot_interval_timer_bank_unit #(
	parameter int NUM_SLOTS = msitb_pkg::NUM_SLOTS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// slot[3:0], interval_ms[35:4], repeat_flag[36], delta_ms[68:37], zero fill
	input  logic [msitb_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// kind[2:0]
	input  logic [msitb_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// result_slot[3:0], zero fill
	output logic [msitb_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	// event_res[1:0]
	output logic [msitb_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
	output logic                                  m_axis_tlast
);
	import msitb_pkg::*;

	cmd_t               cmd;
	stat_t              stat;
	ev_t                out_ev;
	logic [SLOT_W-1:0]  out_slot;

	msitb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	msitb_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.in_kind         (kind_t'(s_axis_tuser)),
		.in_slot         (s_axis_tdata[SLOT_W-1:0]),
		.in_interval_ms  (s_axis_tdata[SLOT_W +: TIME_W]),
		.in_repeat_flag  (s_axis_tdata[SLOT_W + TIME_W]),
		.in_delta_ms     (s_axis_tdata[SLOT_W + TIME_W + 1 +: TIME_W]),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.out_event_res   (out_ev),
		.out_result_slot (out_slot),
		.out_last        (m_axis_tlast)
	);

	// output beat packing
	assign m_axis_tdata = OUT_TDATA_W'(out_slot);
	assign m_axis_tuser = out_ev;

endmodule

>>> design/msitb_chk.sv
// port-level checks of the timer bank, attached by bind
// depends on msitb_pkg and the assertion macro header
module msitb_chk (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	input  logic                                  s_axis_tready,
	input  logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	input  logic [msitb_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	input  logic [msitb_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
	input  logic                                  m_axis_tlast
);
	import msitb_pkg::*;
	`include "multi_slot_interval_timer_bank_unit_macros.svh"

	// a stalled result beat holds
	`MSITB_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result beat changed while stalled")

	// expiry beats never close an item
	`MSITB_ASSERT_NOW(a_expiry_open, m_axis_tvalid && m_axis_tuser == EV_EXPIRED, !m_axis_tlast, "expiry beat with tlast")

	// every other answer closes its item
	`MSITB_ASSERT_NOW(a_answer_last, m_axis_tvalid && m_axis_tuser != EV_EXPIRED, m_axis_tlast, "answer beat without tlast")

	// one command at a time: input closes after each accepted beat
	`MSITB_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")

endmodule

bind multi_slot_interval_timer_bank_unit msitb_chk u_chk (.*);

>>> test/multi_slot_interval_timer_bank_unit_tb.sv
// self-checking bench for the interval timer bank: command beats in, event beats out
// depends on msitb_pkg and multi_slot_interval_timer_bank_unit
module multi_slot_interval_timer_bank_unit_tb;
	import msitb_pkg::*;

	localparam int SLOTS      = 16;
	localparam int CYCLE_CAP  = 200000;
	localparam int RAND_ITEMS = 126;

	typedef struct {
		kind_t       kind;
		logic [3:0]  slot;
		logic [31:0] interval;
		logic        rep;
		logic [31:0] delta;
		bit          hold;   // wait for every owed event before sending
	} cmd_beat_t;

	typedef struct {
		ev_t        ev;
		logic [3:0] slot;
		logic       last;
	} event_beat_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [OUT_TUSER_W-1:0] m_axis_tuser;
	logic                   m_axis_tlast;

	cmd_beat_t   pending_cmds[$];
	event_beat_t expected_events[$];
	cmd_beat_t   on_bus;
	int          total_items = 0;
	int          beats_taken = 0;
	int          mismatches = 0;
	int          cycles = 0;
	int          phase = 0;

	// timer bank image kept by the bench
	bit          tb_used[SLOTS];
	bit          tb_running[SLOTS];
	bit          tb_periodic[SLOTS];
	logic [31:0] tb_period[SLOTS];
	logic [31:0] tb_elapsed[SLOTS];
	int          tb_count = 0;

	// slots the stimulus believes are taken, to aim slot commands
	logic [SLOTS-1:0] gen_used = '0;

	multi_slot_interval_timer_bank_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #10 clk = ~clk;

	function automatic int send_idle(int ph);
		return (ph == 0) ? 30 : (ph == 1) ? 72 : 0;
	endfunction

	function automatic int recv_idle(int ph);
		return (ph == 0) ? 72 : (ph == 1) ? 30 : 0;
	endfunction

	function automatic void owe_event(ev_t ev, logic [3:0] slot, logic last);
		event_beat_t e;
		e.ev = ev;
		e.slot = slot;
		e.last = last;
		expected_events.push_back(e);
	endfunction

	// advance the bank image by one command and queue the events it causes
	function automatic void timer_bank_step(cmd_beat_t c);
		logic [32:0] sum;
		int          s;
		s = c.slot;
		if (c.kind == K_TICK) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (tb_used[i] && tb_running[i]) begin
					sum = {1'b0, tb_elapsed[i]} + {1'b0, c.delta};
					tb_elapsed[i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
					if (tb_elapsed[i] >= tb_period[i]) begin
						owe_event(EV_EXPIRED, 4'(i), 1'b0);
						if (tb_periodic[i])
							tb_elapsed[i] = '0;
						else
							tb_running[i] = 1'b0;
					end
				end
			end
			owe_event(EV_DONE, 4'd0, 1'b1);
		end else if (c.kind == K_ALLOC) begin
			if (tb_count >= SLOTS) begin
				owe_event(EV_REFUSED, 4'd0, 1'b1);
			end else begin
				for (int i = 0; i < SLOTS; i++) begin
					if (!tb_used[i]) begin
						tb_used[i] = 1'b1;
						tb_running[i] = 1'b0;
						tb_periodic[i] = c.rep;
						tb_period[i] = c.interval;
						tb_elapsed[i] = '0;
						tb_count++;
						owe_event(EV_DONE, 4'(i), 1'b1);
						break;
					end
				end
			end
		end else if (!tb_used[s]) begin
			owe_event(EV_REFUSED, c.slot, 1'b1);
		end else begin
			case (c.kind)
				K_RELEASE: begin
					tb_used[s] = 1'b0;
					tb_running[s] = 1'b0;
					if (tb_count > 0)
						tb_count--;
				end
				K_START: begin
					tb_elapsed[s] = '0;
					tb_running[s] = 1'b1;
				end
				K_STOP:       tb_running[s] = 1'b0;
				K_CLEAR:      tb_elapsed[s] = '0;
				K_SET_PERIOD: tb_period[s] = c.interval;
				default:      tb_periodic[s] = c.rep;
			endcase
			owe_event(EV_DONE, c.slot, 1'b1);
		end
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch at cycle %0d: %s got %0d want %0d", cycles, what, got, want);
		mismatches++;
	endtask

	task automatic queue_cmd(kind_t k, int slot, logic [31:0] iv, bit rep,
			logic [31:0] d, bit hold);
		cmd_beat_t c;
		c.kind = k;
		c.slot = 4'(slot);
		c.interval = iv;
		c.rep = rep;
		c.delta = d;
		c.hold = hold;
		pending_cmds.push_back(c);
		total_items++;
		if (k == K_ALLOC) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (!gen_used[i]) begin
					gen_used[i] = 1'b1;
					break;
				end
			end
		end else if (k == K_RELEASE) begin
			gen_used[slot] = 1'b0;
		end
	endtask

	// mostly a slot in use, sometimes any slot
	function automatic int pick_slot();
		int s;
		if (gen_used != '0 && $urandom_range(99) < 80) begin
			do s = $urandom_range(SLOTS - 1); while (!gen_used[s]);
			return s;
		end
		return $urandom_range(SLOTS - 1);
	endfunction

	function automatic logic [31:0] pick_interval();
		int r;
		r = $urandom_range(99);
		if (r < 20)
			return $urandom_range(5);
		if (r < 80)
			return $urandom_range(60);
		return $urandom;
	endfunction

	function automatic logic [31:0] pick_delta();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return '0;
		if (r < 80)
			return $urandom_range(40);
		return $urandom;
	endfunction

	// command driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
			phase <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				timer_bank_step(on_bus);
				beats_taken++;
			end
			phase <= (beats_taken < total_items / 3) ? 0 :
				(beats_taken < 2 * total_items / 3) ? 1 : 2;
			if (!(s_axis_tvalid && !s_axis_tready)) begin
				if (pending_cmds.size() != 0
						&& !(pending_cmds[0].hold && expected_events.size() != 0)
						&& $urandom_range(99) >= send_idle(phase)) begin
					on_bus = pending_cmds.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {3'b000, on_bus.delta, on_bus.rep, on_bus.interval,
						on_bus.slot};
					s_axis_tuser <= on_bus.kind;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// event monitor and back-pressure
	always @(posedge clk or negedge arst_n) begin
		event_beat_t e;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_events.size() == 0) begin
					report_mismatch("unexpected beat, slot", m_axis_tdata[3:0], -1);
				end else begin
					e = expected_events.pop_front();
					if (m_axis_tuser !== e.ev)
						report_mismatch("event_res", m_axis_tuser, e.ev);
					if (m_axis_tdata[3:0] !== e.slot)
						report_mismatch("result_slot", m_axis_tdata[3:0], e.slot);
					if (m_axis_tlast !== e.last)
						report_mismatch("last", m_axis_tlast, e.last);
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_idle(phase));
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_CAP) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int    r;
		kind_t k;
		// directed: empty tick, refusals, zero and full-scale intervals
		queue_cmd(K_TICK, 0, '0, 1'b0, '0, 1'b0);
		queue_cmd(K_START, 15, '0, 1'b0, '0, 1'b0);
		queue_cmd(K_ALLOC, 0, 32'd0, 1'b1, '0, 1'b0);
		queue_cmd(K_ALLOC, 0, 32'hFFFF_FFFF, 1'b0, '0, 1'b0);
		queue_cmd(K_ALLOC, 0, 32'd10, 1'b0, '0, 1'b0);
		queue_cmd(K_START, 0, '0, 1'b0, '0, 1'b0);
		queue_cmd(K_START, 1, '0, 1'b0, '0, 1'b0);
		queue_cmd(K_START, 2, '0, 1'b0, '0, 1'b0);
		// zero interval fires on a zero tick
		queue_cmd(K_TICK, 0, '0, 1'b0, 32'd0, 1'b0);
		queue_cmd(K_TICK, 0, '0, 1'b0, 32'h8000_0000, 1'b0);
		// elapsed time saturates instead of wrapping, one-shot then stops
		queue_cmd(K_TICK, 0, '0, 1'b0, 32'hFFFF_FFFF, 1'b1);
		queue_cmd(K_SET_PERIOD, 2, 32'd5, 1'b0, '0, 1'b0);
		queue_cmd(K_SET_REPEAT, 2, '0, 1'b1, '0, 1'b0);
		queue_cmd(K_CLEAR, 2, '0, 1'b0, '0, 1'b0);
		queue_cmd(K_STOP, 0, '0, 1'b0, '0, 1'b0);
		queue_cmd(K_START, 2, '0, 1'b0, '0, 1'b0);
		queue_cmd(K_TICK, 0, '0, 1'b0, 32'd7, 1'b0);
		queue_cmd(K_RELEASE, 1, '0, 1'b0, '0, 1'b0);
		queue_cmd(K_ALLOC, 0, 32'd3, 1'b1, '0, 1'b0);
		queue_cmd(K_SET_PERIOD, 9, 32'd1, 1'b0, '0, 1'b0);
		queue_cmd(K_SET_REPEAT, 9, '0, 1'b1, '0, 1'b0);
		queue_cmd(K_STOP, 9, '0, 1'b0, '0, 1'b0);
		queue_cmd(K_CLEAR, 9, '0, 1'b0, '0, 1'b0);
		queue_cmd(K_RELEASE, 9, '0, 1'b0, '0, 1'b0);

		// random: mostly slot work on live slots, ticks and the odd fill burst
		while (total_items < 24 + RAND_ITEMS) begin
			r = $urandom_range(99);
			if (r < 4) begin
				repeat (SLOTS + 1)
					queue_cmd(K_ALLOC, $urandom_range(SLOTS - 1), pick_interval(),
						1'($urandom_range(1)), $urandom, 1'b0);
			end else begin
				if (r < 30)
					k = K_TICK;
				else if (r < 45)
					k = K_ALLOC;
				else if (r < 52)
					k = K_RELEASE;
				else if (r < 70)
					k = K_START;
				else
					k = kind_t'($urandom_range(4, 7));
				queue_cmd(k, pick_slot(), pick_interval(), 1'($urandom_range(1)),
					pick_delta(), $urandom_range(99) < 3);
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		do @(posedge clk); while (pending_cmds.size() != 0 || beats_taken < total_items);
		do @(posedge clk); while (expected_events.size() != 0);
		repeat (2 * SLOTS + 8) @(posedge clk);
		if (mismatches == 0 && expected_events.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
